/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OSFG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OSFG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/osfg_pkg.sv */
// types and constants of the odometry sensor fusion gate
package osfg_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned StatusW  = 8;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned StreakW  = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef logic [TimeW-1:0]    time_ms_t;
  typedef logic [StatusW-1:0]  status_t;
  typedef logic [DelayW-1:0]   delay_t;
  typedef logic [StreakW-1:0]  streak_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_FRESH = 2'd1,
    ACT_STALE = 2'd2
  } telem_act_t;

  localparam cfg_idx_t REG_HARD_ERROR_MASK     = 8'd0;
  localparam cfg_idx_t REG_LOST_DELAY_MS       = 8'd1;
  localparam cfg_idx_t REG_WARN_PERSIST_LIMIT  = 8'd2;
  localparam cfg_idx_t REG_CLEAN_READMIT_COUNT = 8'd3;

  localparam status_t RST_HARD_ERROR_MASK     = 8'hC0;
  localparam delay_t  RST_LOST_DELAY_MS       = 16'd500;
  localparam streak_t RST_WARN_PERSIST_LIMIT  = 8'd5;
  localparam streak_t RST_CLEAN_READMIT_COUNT = 8'd3;
  localparam streak_t STREAK_MAX              = 8'hFF;

  typedef struct packed {
    logic     sensor_ready;
    logic     status_read_ok;
    status_t  status_bits;
    logic     pose_read_ok;
    logic     velocity_read_ok;
    logic     motion_active;
    time_ms_t time_ms;
  } item_t;

  typedef struct packed {
    telem_act_t telemetry_action;
    logic       lost_event;
    logic       fuse_now;
    logic       zero_velocity;
  } result_t;

  typedef struct packed {
    status_t hard_error_mask;
    delay_t  lost_delay_ms;
    streak_t warn_persist_limit;
    streak_t clean_readmit_count;
  } cfg_t;

  typedef struct packed {
    time_ms_t invalid_start_time;
    logic     lost_reported;
    streak_t  warn_streak;
    streak_t  clean_streak;
    logic     fusion_blocked;
  } gate_state_t;

endpackage

/* hdl/osfg_if.sv */
// valid/ready channel interfaces for input items, results and register writes
interface osfg_in_if;
  import osfg_pkg::*;
  logic     valid;
  logic     ready;
  logic     sensor_ready;
  logic     status_read_ok;
  status_t  status_bits;
  logic     pose_read_ok;
  logic     velocity_read_ok;
  logic     motion_active;
  time_ms_t time_ms;

  modport source (
    output valid, sensor_ready, status_read_ok, status_bits, pose_read_ok,
           velocity_read_ok, motion_active, time_ms,
    input  ready
  );
  modport sink (
    input  valid, sensor_ready, status_read_ok, status_bits, pose_read_ok,
           velocity_read_ok, motion_active, time_ms,
    output ready
  );
endinterface

interface osfg_out_if;
  import osfg_pkg::*;
  logic       valid;
  logic       ready;
  telem_act_t telemetry_action;
  logic       lost_event;
  logic       fuse_now;
  logic       zero_velocity;

  modport source (
    output valid, telemetry_action, lost_event, fuse_now, zero_velocity,
    input  ready
  );
  modport sink (
    input  valid, telemetry_action, lost_event, fuse_now, zero_velocity,
    output ready
  );
endinterface

interface osfg_cfg_if;
  import osfg_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  idx;
  cfg_data_t data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

/* hdl/odometry_sensor_fusion_gate.sv */
// top level of the odometry sensor fusion gate
//
//  channel  | dir | transfer carries
//  ---------+-----+-------------------------------------------------------------
//  in_ch    | in  | one control tick: ready flag, read results, status, motion, time
//  out_ch   | out | one decision per tick: telemetry action, lost event, fuse flags
//  cfg_ch   | in  | register write: index 0..3 and data, always ready
//
//  one tick per cycle unless out_ch stalls; input register, then result register
//  the gate state updates as a tick moves into the result register, one update per cycle
//  rst_n low restores register defaults and clears all gate state
//  a stalled out_ch holds the result; in_ch keeps flowing until the input register fills
`include "assert_macros.svh"

module odometry_sensor_fusion_gate (
  input  logic        clk,
  input  logic        rst_n,
  osfg_in_if.sink     in_ch,
  osfg_out_if.source  out_ch,
  osfg_cfg_if.sink    cfg_ch
);
  import osfg_pkg::*;

  logic        in_vld_r;
  item_t       in_item_r;
  logic        out_vld_r;
  result_t     out_res_r;
  cfg_t        cfg_r;
  gate_state_t st_r;
  gate_state_t st_nxt;
  result_t     res_nxt;
  logic        in_xfer;
  logic        adv;

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  osfg_core u_core (
    .item   (in_item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  // control, state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r                  <= 1'b0;
      out_vld_r                 <= 1'b0;
      cfg_r.hard_error_mask     <= RST_HARD_ERROR_MASK;
      cfg_r.lost_delay_ms       <= RST_LOST_DELAY_MS;
      cfg_r.warn_persist_limit  <= RST_WARN_PERSIST_LIMIT;
      cfg_r.clean_readmit_count <= RST_CLEAN_READMIT_COUNT;
      st_r                      <= '0;
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.idx)
          REG_HARD_ERROR_MASK:     cfg_r.hard_error_mask     <= cfg_ch.data[StatusW-1:0];
          REG_LOST_DELAY_MS:       cfg_r.lost_delay_ms       <= cfg_ch.data[DelayW-1:0];
          REG_WARN_PERSIST_LIMIT:  cfg_r.warn_persist_limit  <= cfg_ch.data[StreakW-1:0];
          REG_CLEAN_READMIT_COUNT: cfg_r.clean_readmit_count <= cfg_ch.data[StreakW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.sensor_ready     <= in_ch.sensor_ready;
      in_item_r.status_read_ok   <= in_ch.status_read_ok;
      in_item_r.status_bits      <= in_ch.status_bits;
      in_item_r.pose_read_ok     <= in_ch.pose_read_ok;
      in_item_r.velocity_read_ok <= in_ch.velocity_read_ok;
      in_item_r.motion_active    <= in_ch.motion_active;
      in_item_r.time_ms          <= in_ch.time_ms;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.telemetry_action = out_res_r.telemetry_action;
  assign out_ch.lost_event       = out_res_r.lost_event;
  assign out_ch.fuse_now         = out_res_r.fuse_now;
  assign out_ch.zero_velocity    = out_res_r.zero_velocity;

  `OSFG_ASSERT_IMP(a_zero_vel_needs_fuse, out_vld_r && out_res_r.zero_velocity, out_res_r.fuse_now, "zero velocity without fuse")
  `OSFG_ASSERT_IMP(a_fuse_only_fresh, out_vld_r && out_res_r.fuse_now, out_res_r.telemetry_action == ACT_FRESH, "fuse on a reading that is not fresh")
  `OSFG_ASSERT_IMP(a_lost_only_stale, out_vld_r && out_res_r.lost_event, out_res_r.telemetry_action == ACT_STALE, "lost event on a healthy reading")
  `OSFG_ASSERT_NXT(a_lost_latched, adv && res_nxt.lost_event, st_r.lost_reported && out_vld_r, "lost event not latched")

endmodule

/* hdl/osfg_core.sv */
// per-tick decision logic: health check, lost window, warn and clean streaks
module osfg_core (
  input  osfg_pkg::item_t       item,
  input  osfg_pkg::cfg_t        cfg,
  input  osfg_pkg::gate_state_t st,
  output osfg_pkg::result_t     res,
  output osfg_pkg::gate_state_t st_nxt
);
  import osfg_pkg::*;

  logic     readable;
  logic     healthy;
  time_ms_t start_eff;
  time_ms_t elapsed;
  streak_t  warn_inc;
  streak_t  clean_inc;

  assign readable  = item.status_read_ok && ((item.status_bits & cfg.hard_error_mask) == '0);
  assign healthy   = readable && item.pose_read_ok;
  assign start_eff = (st.invalid_start_time == '0) ? item.time_ms : st.invalid_start_time;
  assign elapsed   = item.time_ms - start_eff;
  assign warn_inc  = (st.warn_streak == STREAK_MAX) ? STREAK_MAX : st.warn_streak + 8'd1;
  assign clean_inc = st.clean_streak + 8'd1;

  always_comb begin
    st_nxt               = st;
    res.telemetry_action = ACT_NONE;
    res.lost_event       = 1'b0;
    res.fuse_now         = 1'b0;
    res.zero_velocity    = 1'b0;
    if (item.sensor_ready) begin
      if (!healthy) begin
        res.telemetry_action = ACT_STALE;
        if (item.motion_active) begin
          st_nxt.invalid_start_time = start_eff;
          if (!st.lost_reported && (elapsed >= {{(TimeW-DelayW){1'b0}}, cfg.lost_delay_ms})) begin
            res.lost_event       = 1'b1;
            st_nxt.lost_reported = 1'b1;
          end
        end
      end else begin
        res.telemetry_action      = ACT_FRESH;
        st_nxt.invalid_start_time = '0;
        st_nxt.lost_reported      = 1'b0;
        if (item.status_bits != '0) begin
          st_nxt.warn_streak  = warn_inc;
          st_nxt.clean_streak = '0;
          if (warn_inc > cfg.warn_persist_limit) begin
            st_nxt.fusion_blocked = 1'b1;
          end
        end else begin
          st_nxt.warn_streak = '0;
          if (st.fusion_blocked) begin
            if (clean_inc >= cfg.clean_readmit_count) begin
              st_nxt.fusion_blocked = 1'b0;
              st_nxt.clean_streak   = '0;
            end else begin
              st_nxt.clean_streak = clean_inc;
            end
          end
        end
        res.fuse_now      = !st_nxt.fusion_blocked;
        res.zero_velocity = !st_nxt.fusion_blocked && !item.velocity_read_ok;
      end
    end
  end

endmodule
